>>> rtl/core/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier core.
// ----------------------------------------------------------------------------
package bcc_pkg;

	// timer and register widths
	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int CNT_W      = 3;
	localparam int EV_W       = 3;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = 2;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
	localparam logic [CNT_W-1:0]      CLICK_MAX = {CNT_W{1'b1}};

	// register indexes (byte address / 4)
	localparam logic [IDX_W-1:0] REG_PRESS_MIN   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
	localparam logic [IDX_W-1:0] REG_RELEASE_MAX = 2'd2;

	// reset values of the registers
	localparam logic [CFG_W-1:0] RST_PRESS_MIN   = 16'd50;
	localparam logic [CFG_W-1:0] RST_LONG_PRESS  = 16'd1000;
	localparam logic [CFG_W-1:0] RST_RELEASE_MAX = 16'd300;

	// event codes
	typedef enum logic [EV_W-1:0] {
		EV_NONE   = 3'd0,
		EV_SINGLE = 3'd1,
		EV_DOUBLE = 3'd2,
		EV_TRIPLE = 3'd3,
		EV_MANY   = 3'd4,
		EV_LONG   = 3'd5
	} ev_t;

	// thresholds handed from the register block to the tracker
	typedef struct packed {
		logic [CFG_W-1:0] press_min;
		logic [CFG_W-1:0] long_press;
		logic [CFG_W-1:0] release_max;
	} cfg_t;

	// tracker status for checks
	typedef struct packed {
		logic             pressing;
		logic [CNT_W-1:0] click_count;
	} trk_status_t;

endpackage

>>> rtl/core/bcc_cfg.sv
// ----------------------------------------------------------------------------
// bcc_cfg
// APB-style register block holding the three tick thresholds.
// ----------------------------------------------------------------------------
module bcc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bcc_pkg::ADDR_W-1:0]  paddr,
	input  logic [bcc_pkg::DATA_W-1:0]  pwdata,
	output logic [bcc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output bcc_pkg::cfg_t               cfg
);

	logic [bcc_pkg::IDX_W-1:0] idx;
	logic                      wr_en;
	logic [bcc_pkg::CFG_W-1:0] wdata;
	bcc_pkg::cfg_t             cfg_q;

	assign idx    = paddr[bcc_pkg::ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign wdata  = pwdata[bcc_pkg::CFG_W-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_min   <= bcc_pkg::RST_PRESS_MIN;
			cfg_q.long_press  <= bcc_pkg::RST_LONG_PRESS;
			cfg_q.release_max <= bcc_pkg::RST_RELEASE_MAX;
		end else if (wr_en) begin
			case (idx)
				bcc_pkg::REG_PRESS_MIN:   cfg_q.press_min   <= wdata;
				bcc_pkg::REG_LONG_PRESS:  cfg_q.long_press  <= wdata;
				bcc_pkg::REG_RELEASE_MAX: cfg_q.release_max <= wdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			bcc_pkg::REG_PRESS_MIN:
				prdata = bcc_pkg::DATA_W'(cfg_q.press_min);
			bcc_pkg::REG_LONG_PRESS:
				prdata = bcc_pkg::DATA_W'(cfg_q.long_press);
			bcc_pkg::REG_RELEASE_MAX:
				prdata = bcc_pkg::DATA_W'(cfg_q.release_max);
			default:
				prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/bcc_track.sv
// ----------------------------------------------------------------------------
// bcc_track
// Press/release timers, click counter and event decision for one tick.
// ----------------------------------------------------------------------------
module bcc_track (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic                 level,
	input  bcc_pkg::cfg_t        cfg,
	output bcc_pkg::ev_t         ev,
	output bcc_pkg::trk_status_t status
);

	logic                            pressing_q, pressing_d;
	logic [bcc_pkg::TIMER_BITS-1:0]  press_q, press_d;
	logic [bcc_pkg::TIMER_BITS-1:0]  rel_q, rel_d;
	logic [bcc_pkg::CNT_W-1:0]       cnt_q, cnt_d;

	logic [bcc_pkg::TIMER_BITS-1:0]  press_inc;
	logic [bcc_pkg::TIMER_BITS-1:0]  rel_inc;
	logic [bcc_pkg::CMP_W-1:0]       press_x, rel_x, min_x, long_x, rmax_x;

	// saturating increments
	assign press_inc = (press_q == bcc_pkg::TIMER_MAX) ? press_q : press_q + 1'b1;
	assign rel_inc   = (rel_q == bcc_pkg::TIMER_MAX) ? rel_q : rel_q + 1'b1;

	// common compare width
	assign press_x = bcc_pkg::CMP_W'(press_inc);
	assign rel_x   = bcc_pkg::CMP_W'(rel_inc);
	assign min_x   = bcc_pkg::CMP_W'(cfg.press_min);
	assign long_x  = bcc_pkg::CMP_W'(cfg.long_press);
	assign rmax_x  = bcc_pkg::CMP_W'(cfg.release_max);

	// next state and event for this tick
	always_comb begin
		pressing_d = pressing_q;
		press_d    = press_q;
		rel_d      = rel_inc;
		cnt_d      = cnt_q;
		ev         = bcc_pkg::EV_NONE;
		if (level) begin
			if (!pressing_q) begin
				pressing_d = 1'b1;
				press_d    = '0;
			end else begin
				press_d = press_inc;
				if (press_x >= long_x && cnt_q == '0) begin
					ev    = bcc_pkg::EV_LONG;
					cnt_d = bcc_pkg::CNT_W'(1);
				end
			end
		end else if (pressing_q) begin
			// release: press length is press_inc
			pressing_d = 1'b0;
			press_d    = '0;
			if (press_x < min_x) begin
				// bounce, nothing else changes
			end else if (press_x < long_x) begin
				rel_d = '0;
				if (cnt_q != bcc_pkg::CLICK_MAX) cnt_d = cnt_q + 1'b1;
			end else begin
				rel_d = '0;
				cnt_d = '0;
			end
		end else if (cnt_q != '0 && rel_x > rmax_x) begin
			case (cnt_q)
				3'd1:    ev = bcc_pkg::EV_SINGLE;
				3'd2:    ev = bcc_pkg::EV_DOUBLE;
				3'd3:    ev = bcc_pkg::EV_TRIPLE;
				default: ev = bcc_pkg::EV_MANY;
			endcase
			rel_d = '0;
			cnt_d = '0;
		end
	end

	// state registers advance once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressing_q <= 1'b0;
			press_q    <= '0;
			rel_q      <= '0;
			cnt_q      <= '0;
		end else if (tick) begin
			pressing_q <= pressing_d;
			press_q    <= press_d;
			rel_q      <= rel_d;
			cnt_q      <= cnt_d;
		end
	end

	assign status.pressing    = pressing_q;
	assign status.click_count = cnt_q;

endmodule

>>> rtl/core/button_click_classifier_core.sv
// ----------------------------------------------------------------------------
// button_click_classifier_core
// Classifies a ticked button level into clicks, multi-clicks and long press.
//
//   channel | direction | handshake           | payload
//   in      | to core   | in_valid / in_stall | button_pressed
//   out     | from core | out_valid/out_stall | event_code
//   cfg     | to core   | APB psel/penable    | paddr, pwdata, prdata
//
// One beat per cycle while out is not stalled; each input beat yields one result
// beat, passing through the input register, then the result register.
// The tracker state updates in the cycle a beat leaves the input register.
// Reset clears the timers, the click count and both valid flags; registers
// return to their default thresholds.
// A stall on out holds the result register and backs up into in_stall.
// ----------------------------------------------------------------------------
module button_click_classifier_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        button_pressed,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bcc_pkg::EV_W-1:0]    event_code,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bcc_pkg::ADDR_W-1:0]  paddr,
	input  logic [bcc_pkg::DATA_W-1:0]  pwdata,
	output logic [bcc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	bcc_pkg::cfg_t        cfg;
	bcc_pkg::ev_t         cur_ev;
	bcc_pkg::trk_status_t status;

	logic         valid_s1;
	logic         level_s1;
	logic         adv_s1;
	logic         out_free;
	logic         valid_s2;
	bcc_pkg::ev_t ev_s2;

	// stage handoff
	assign out_free = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			level_s1 <= button_pressed;
		end
	end

	bcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcc_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (adv_s1),
		.level  (level_s1),
		.cfg    (cfg),
		.ev     (cur_ev),
		.status (status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ev_s2 <= cur_ev;
		end
	end

	assign out_valid  = valid_s2;
	assign event_code = ev_s2;

	// checks
	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("in_stall without a held beat");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_code <= bcc_pkg::EV_LONG))
		else $error("event code out of range");

	a_long_while_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cur_ev == bcc_pkg::EV_LONG) |-> (status.pressing && level_s1))
		else $error("long press reported without a held press");

	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cur_ev != bcc_pkg::EV_NONE && cur_ev != bcc_pkg::EV_LONG)
		|=> (status.click_count == '0 && !status.pressing))
		else $error("click report did not clear the series");

endmodule
